>>> rtl/ipwp_pkg.sv
// ----------------------------------------------------------------------------
// ipwp_pkg
// Shared types and constants for the isochronous packet window packer.
// ----------------------------------------------------------------------------
package ipwp_pkg;

  localparam int WINDOW_SLOTS  = 8;      // packets per window, 1..8
  localparam int MAX_SLOTS     = 8;      // slots carried by the result fields
  localparam int ADDR_W        = 32;
  localparam int LEN_W         = 12;
  localparam int FRAME_W       = 16;
  localparam int COUNT_W       = 4;
  localparam int BYTES_W       = 15;
  localparam int LOOK_W        = 8;
  localparam int PAGE_OFFSET_W = 12;
  localparam int PAGE_W        = ADDR_W - PAGE_OFFSET_W;
  localparam int SLOT_IDX_W    = 3;
  localparam int LENS_W        = 4 * LEN_W;

  localparam logic [LOOK_W-1:0] LOOKAHEAD_RESET = 8'd2;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  packet_address;
    logic [LEN_W-1:0]   packet_length;
    logic               first_of_transfer;
    logic               last_of_transfer;
    logic [FRAME_W-1:0] frame_now;
    logic [FRAME_W-1:0] tail_frame;
    logic               tail_valid;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] start_frame;
    logic [COUNT_W-1:0] packet_count;
    logic [ADDR_W-1:0]  window_address;
    logic [BYTES_W-1:0] window_bytes;
    logic [ADDR_W-1:0]  page_base;
    logic [LENS_W-1:0]  lengths_low;
    logic [LENS_W-1:0]  lengths_high;
    logic               last_window;
  } window_t;

  // write strobes from the packer into the result queue
  typedef struct packed {
    logic push0;   // window the packet could not join
    logic push1;   // final window of the transfer
  } push_t;

endpackage

>>> rtl/ipwp_ifs.sv
// ----------------------------------------------------------------------------
// ipwp channel interfaces
// Valid/ready channels for packets in, windows out and configuration writes.
// ----------------------------------------------------------------------------
interface ipwp_in_if;
  import ipwp_pkg::*;
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  packet_address;
  logic [LEN_W-1:0]   packet_length;
  logic               first_of_transfer;
  logic               last_of_transfer;
  logic [FRAME_W-1:0] frame_now;
  logic [FRAME_W-1:0] tail_frame;
  logic               tail_valid;

  modport source (output valid, packet_address, packet_length, first_of_transfer,
                  last_of_transfer, frame_now, tail_frame, tail_valid,
                  input ready);
  modport sink (input valid, packet_address, packet_length, first_of_transfer,
                last_of_transfer, frame_now, tail_frame, tail_valid,
                output ready);
endinterface

interface ipwp_out_if;
  import ipwp_pkg::*;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] start_frame;
  logic [COUNT_W-1:0] packet_count;
  logic [ADDR_W-1:0]  window_address;
  logic [BYTES_W-1:0] window_bytes;
  logic [ADDR_W-1:0]  page_base;
  logic [LENS_W-1:0]  lengths_low;
  logic [LENS_W-1:0]  lengths_high;
  logic               last_window;

  modport source (output valid, start_frame, packet_count, window_address,
                  window_bytes, page_base, lengths_low, lengths_high, last_window,
                  input ready);
  modport sink (input valid, start_frame, packet_count, window_address,
                window_bytes, page_base, lengths_low, lengths_high, last_window,
                output ready);
endinterface

interface ipwp_cfg_if;
  import ipwp_pkg::*;
  logic              valid;
  logic              ready;
  logic [LOOK_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/isoc_packet_window_packer.sv
// ----------------------------------------------------------------------------
// isoc_packet_window_packer
// Packs the isochronous packets of a transfer into contiguous windows.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one packet per transfer: address, length, transfer start and
//   end flags, and the frame fields sampled on the first packet.
//   out_ch carries one closed window per transfer, with its start frame,
//   packet count, byte total, page base and the slot lengths.
//   cfg_ch writes prime_lookahead; it is always ready and should only be
//   written while the block is idle.
// Throughput and queueing:
//   One packet is taken every cycle while the result queue has room for two
//   windows. A packet's windows are queued at its transfer, behind any still
//   waiting. A packet may close up to two windows, and out_ch drains one a
//   cycle, so the output port sets the sustained rate when windows are short.
// Reset:
//   rst_n (synchronous) closes any open window, zeroes the frame counter,
//   empties the result queue and sets prime_lookahead to 2.
// Stalls:
//   While out_ch is stalled, windows wait in a four-entry queue; in_ch.ready
//   drops once fewer than two entries are free and returns as results drain.
// ----------------------------------------------------------------------------
module isoc_packet_window_packer (
  input logic       clk,
  input logic       rst_n,
  ipwp_in_if.sink   in_ch,
  ipwp_out_if.source out_ch,
  ipwp_cfg_if.sink  cfg_ch
);
  import ipwp_pkg::*;

  in_item_t in_item;
  push_t    push;
  window_t  win0;
  window_t  win1;
  window_t  out_win;
  logic     space_ok;
  logic     in_fire;
  logic     cfg_fire;

  // gather the packet fields for the packer
  assign in_item.packet_address    = in_ch.packet_address;
  assign in_item.packet_length     = in_ch.packet_length;
  assign in_item.first_of_transfer = in_ch.first_of_transfer;
  assign in_item.last_of_transfer  = in_ch.last_of_transfer;
  assign in_item.frame_now         = in_ch.frame_now;
  assign in_item.tail_frame        = in_ch.tail_frame;
  assign in_item.tail_valid        = in_ch.tail_valid;

  // accept a packet only when both windows it may close fit in the queue
  assign in_ch.ready = space_ok;
  assign in_fire     = in_ch.valid && space_ok;

  // configuration writes never stall
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  ipwp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_item  (in_item),
    .cfg_fire (cfg_fire),
    .cfg_data (cfg_ch.data),
    .push     (push),
    .win0     (win0),
    .win1     (win1)
  );

  ipwp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .win0      (win0),
    .win1      (win1),
    .space_ok  (space_ok),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_win   (out_win)
  );

  // drive the window fields from the head of the queue
  assign out_ch.start_frame    = out_win.start_frame;
  assign out_ch.packet_count   = out_win.packet_count;
  assign out_ch.window_address = out_win.window_address;
  assign out_ch.window_bytes   = out_win.window_bytes;
  assign out_ch.page_base      = out_win.page_base;
  assign out_ch.lengths_low    = out_win.lengths_low;
  assign out_ch.lengths_high   = out_win.lengths_high;
  assign out_ch.last_window    = out_win.last_window;

endmodule

>>> rtl/ipwp_core.sv
// ----------------------------------------------------------------------------
// ipwp_core
// Window state and combinational packing decision for one packet per transfer.
// ----------------------------------------------------------------------------
module ipwp_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_fire,
  input  ipwp_pkg::in_item_t               in_item,
  input  logic                             cfg_fire,
  input  logic [ipwp_pkg::LOOK_W-1:0]      cfg_data,
  output ipwp_pkg::push_t                  push,
  output ipwp_pkg::window_t                win0,
  output ipwp_pkg::window_t                win1
);
  import ipwp_pkg::*;

  logic               window_open_r;
  logic [PAGE_W-1:0]  open_page_r;
  logic [ADDR_W-1:0]  open_addr_r;
  logic [BYTES_W-1:0] open_bytes_r;
  logic [ADDR_W-1:0]  expected_r;
  logic [COUNT_W-1:0] open_count_r;
  len_t               slot_r [MAX_SLOTS];
  logic [FRAME_W-1:0] next_frame_r;
  logic [LOOK_W-1:0]  lookahead_r;

  logic [FRAME_W-1:0] lead;
  logic               tail_ok;
  logic [FRAME_W-1:0] base_frame;
  logic               live;
  logic [ADDR_W-1:0]  end_addr;
  logic [PAGE_W-1:0]  end_page;
  logic               page_ok;
  logic               fits;
  logic               emit0;
  logic [FRAME_W-1:0] frame_mid;
  logic [FRAME_W-1:0] frame_nxt;

  logic [PAGE_W-1:0]  page_nxt;
  logic [ADDR_W-1:0]  addr_nxt;
  logic [BYTES_W-1:0] bytes_nxt;
  logic [COUNT_W-1:0] count_nxt;
  len_t               slot_nxt [MAX_SLOTS];

  function automatic window_t make_window(
    input logic [FRAME_W-1:0] frame,
    input logic [COUNT_W-1:0] count,
    input logic [ADDR_W-1:0]  addr,
    input logic [BYTES_W-1:0] bytes,
    input logic [PAGE_W-1:0]  page,
    input len_t               slots [MAX_SLOTS],
    input logic               last
  );
    window_t w;
    w.start_frame    = frame;
    w.packet_count   = count;
    w.window_address = addr;
    w.window_bytes   = bytes;
    w.page_base      = {page, {PAGE_OFFSET_W{1'b0}}};
    w.lengths_low    = {slots[3], slots[2], slots[1], slots[0]};
    w.lengths_high   = {slots[7], slots[6], slots[5], slots[4]};
    w.last_window    = last;
    return w;
  endfunction

  always_comb begin
    lead       = in_item.tail_frame - in_item.frame_now;
    tail_ok    = in_item.tail_valid && (lead != '0) && !lead[FRAME_W-1];
    if (in_item.first_of_transfer) begin
      base_frame = tail_ok ? in_item.tail_frame
                           : in_item.frame_now + {{(FRAME_W-LOOK_W){1'b0}}, lookahead_r};
    end else begin
      base_frame = next_frame_r;
    end

    // a new transfer drops any stale open window
    live     = window_open_r && !in_item.first_of_transfer;
    end_addr = in_item.packet_address + {{(ADDR_W-LEN_W){1'b0}}, in_item.packet_length}
               - {{(ADDR_W-1){1'b0}}, 1'b1};
    end_page = end_addr[ADDR_W-1:PAGE_OFFSET_W];
    page_ok  = (in_item.packet_length == '0) || (end_page == open_page_r) ||
               (end_page == open_page_r + {{(PAGE_W-1){1'b0}}, 1'b1});
    fits     = live && (open_count_r < COUNT_W'(WINDOW_SLOTS)) &&
               (in_item.packet_address == expected_r) && page_ok;
    emit0    = live && !fits;

    frame_mid = base_frame + (emit0 ? {{(FRAME_W-COUNT_W){1'b0}}, open_count_r} : '0);

    if (fits) begin
      page_nxt  = open_page_r;
      addr_nxt  = open_addr_r;
      bytes_nxt = open_bytes_r + {{(BYTES_W-LEN_W){1'b0}}, in_item.packet_length};
      count_nxt = open_count_r + {{(COUNT_W-1){1'b0}}, 1'b1};
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_nxt[i] = slot_r[i];
      end
      slot_nxt[open_count_r[SLOT_IDX_W-1:0]] = in_item.packet_length;
    end else begin
      page_nxt  = in_item.packet_address[ADDR_W-1:PAGE_OFFSET_W];
      addr_nxt  = in_item.packet_address;
      bytes_nxt = {{(BYTES_W-LEN_W){1'b0}}, in_item.packet_length};
      count_nxt = {{(COUNT_W-1){1'b0}}, 1'b1};
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_nxt[i] = '0;
      end
      slot_nxt[0] = in_item.packet_length;
    end

    // the final window advances the frame past itself
    frame_nxt = in_item.last_of_transfer
                ? frame_mid + {{(FRAME_W-COUNT_W){1'b0}}, count_nxt}
                : frame_mid;

    push.push0 = in_fire && emit0;
    push.push1 = in_fire && in_item.last_of_transfer;
    win0 = make_window(base_frame, open_count_r, open_addr_r, open_bytes_r,
                       open_page_r, slot_r, 1'b0);
    win1 = make_window(frame_mid, count_nxt, addr_nxt, bytes_nxt,
                       page_nxt, slot_nxt, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_open_r <= 1'b0;
      open_page_r   <= '0;
      open_addr_r   <= '0;
      open_bytes_r  <= '0;
      expected_r    <= '0;
      open_count_r  <= '0;
      next_frame_r  <= '0;
      lookahead_r   <= LOOKAHEAD_RESET;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_r[i] <= '0;
      end
    end else begin
      if (cfg_fire) begin
        lookahead_r <= cfg_data;
      end
      if (in_fire) begin
        window_open_r <= !in_item.last_of_transfer;
        open_page_r   <= page_nxt;
        open_addr_r   <= addr_nxt;
        open_bytes_r  <= bytes_nxt;
        expected_r    <= in_item.packet_address +
                         {{(ADDR_W-LEN_W){1'b0}}, in_item.packet_length};
        open_count_r  <= count_nxt;
        next_frame_r  <= frame_nxt;
        for (int i = 0; i < MAX_SLOTS; i++) begin
          slot_r[i] <= slot_nxt[i];
        end
      end
    end
  end

endmodule

>>> rtl/ipwp_out_fifo.sv
// ----------------------------------------------------------------------------
// ipwp_out_fifo
// Small result queue taking up to two windows per cycle, draining one.
// ----------------------------------------------------------------------------
module ipwp_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  ipwp_pkg::push_t   push,
  input  ipwp_pkg::window_t win0,
  input  ipwp_pkg::window_t win1,
  output logic              space_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output ipwp_pkg::window_t out_win
);
  import ipwp_pkg::*;

  window_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_r;
  logic [FIFO_PTR_W-1:0]  rd_ptr_r;
  logic [FIFO_CNT_W-1:0]  count_r;
  logic                   pop;

  assign out_valid = (count_r != '0);
  assign out_win   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // room for the two windows one packet can close
  assign space_ok  = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= win0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_r + FIFO_PTR_W'(push.push0)] <= win1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(push.push0) + FIFO_PTR_W'(push.push1);
      rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(pop);
      count_r  <= count_r + FIFO_CNT_W'(push.push0) + FIFO_CNT_W'(push.push1)
                  - FIFO_CNT_W'(pop);
    end
  end

endmodule

>>> tb/isoc_packet_window_packer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoc_packet_window_packer_tb
// Drives packets of isochronous transfers into the window packer and checks
// every closed window, field by field, against a local packing predictor.
// A short table of directed packets comes first: frame selection corners
// (typed in), then full, page-split, broken, wrapped and stale windows. It
// is followed by random transfers and noise under several lookahead
// settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module isoc_packet_window_packer_tb;
  import ipwp_pkg::*;

  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  PHASE_ITEMS  = 200;
  localparam int  IDLE_PCT     = 21;
  localparam int  SETTLE_TICKS = 4;
  localparam int  PLAN_ROWS    = 25;
  localparam window_t NO_WINDOW = '0;

  typedef struct {
    in_item_t pkt;
    bit       typed;   // want holds the hand-written final window of this row
    window_t  want;
  } row_t;

  logic clk;
  logic rst_n;

  ipwp_in_if  in_ch ();
  ipwp_out_if out_ch ();
  ipwp_cfg_if cfg_ch ();

  isoc_packet_window_packer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the packer's window registers
  // --------------------------------------------------------------------------
  logic [LOOK_W-1:0]  pk_lookahead;
  bit                 pk_open;
  logic [PAGE_W-1:0]  pk_page;
  logic [ADDR_W-1:0]  pk_addr;
  logic [BYTES_W-1:0] pk_bytes;
  logic [ADDR_W-1:0]  pk_next_addr;
  logic [COUNT_W-1:0] pk_count;
  len_t               pk_lens [MAX_SLOTS];
  logic [FRAME_W-1:0] pk_frame;

  window_t windows_due [$];   // windows the packer owes us, oldest first
  window_t fresh [$];         // windows closed by the packet just transferred

  int  errors          = 0;
  int  packets_sent    = 0;
  int  windows_checked = 0;
  int  settings_used   = 1;
  int  cycle_count     = 0;
  bit  calm;                  // suppress all random idling while set

  task automatic flag_error(input string what, input logic [63:0] got,
                            input logic [63:0] want);
    errors++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // Close the open window: queue it and advance the frame by its packet count.
  function automatic void close_window(input bit final_flag);
    window_t w;
    w.start_frame    = pk_frame;
    w.packet_count   = pk_count;
    w.window_address = pk_addr;
    w.window_bytes   = pk_bytes;
    w.page_base      = {pk_page, 12'h000};
    w.lengths_low    = {pk_lens[3], pk_lens[2], pk_lens[1], pk_lens[0]};
    w.lengths_high   = {pk_lens[7], pk_lens[6], pk_lens[5], pk_lens[4]};
    w.last_window    = final_flag;
    fresh.push_back(w);
    pk_frame = pk_frame + {12'd0, pk_count};
    pk_open  = 1'b0;
  endfunction

  // Greedy packing of one packet; closed windows land in fresh.
  function automatic void pack_packet(input in_item_t p);
    logic [FRAME_W-1:0] lead;
    logic [ADDR_W-1:0]  end_addr;
    logic [PAGE_W-1:0]  end_page;
    bit                 fits;
    fits = 1'b0;
    // A transfer start drops any stale window and picks the start frame:
    // the tail frame only when it is strictly ahead in signed 16-bit terms.
    if (p.first_of_transfer) begin
      lead    = p.tail_frame - p.frame_now;
      pk_open = 1'b0;
      if (p.tail_valid && lead != '0 && !lead[FRAME_W-1])
        pk_frame = p.tail_frame;
      else
        pk_frame = p.frame_now + {8'd0, pk_lookahead};
    end
    if (pk_open && pk_count < WINDOW_SLOTS && p.packet_address == pk_next_addr) begin
      if (p.packet_length == '0) begin
        fits = 1'b1;
      end else begin
        end_addr = p.packet_address + {20'd0, p.packet_length} - 32'd1;
        end_page = end_addr[ADDR_W-1:PAGE_OFFSET_W];
        fits = (end_page == pk_page) || (end_page == pk_page + 20'd1);
      end
    end
    if (pk_open && !fits)
      close_window(1'b0);
    if (fits) begin
      pk_lens[pk_count[SLOT_IDX_W-1:0]] = p.packet_length;
      pk_bytes     = pk_bytes + {3'd0, p.packet_length};
      pk_next_addr = p.packet_address + {20'd0, p.packet_length};
      pk_count     = pk_count + 4'd1;
    end else begin
      foreach (pk_lens[s]) pk_lens[s] = '0;
      pk_open      = 1'b1;
      pk_page      = p.packet_address[ADDR_W-1:PAGE_OFFSET_W];
      pk_addr      = p.packet_address;
      pk_bytes     = {3'd0, p.packet_length};
      pk_next_addr = p.packet_address + {20'd0, p.packet_length};
      pk_count     = 4'd1;
      pk_lens[0]   = p.packet_length;
    end
    if (p.last_of_transfer)
      close_window(1'b1);
  endfunction

  function automatic in_item_t mk_packet(input logic [31:0] addr, input len_t len,
                                         input bit first, input bit last,
                                         input logic [15:0] now, input logic [15:0] tail,
                                         input bit tv);
    in_item_t p;
    p.packet_address    = addr;
    p.packet_length     = len;
    p.first_of_transfer = first;
    p.last_of_transfer  = last;
    p.frame_now         = now;
    p.tail_frame        = tail;
    p.tail_valid        = tv;
    return p;
  endfunction

  function automatic window_t mk_window(input logic [15:0] frame, input logic [3:0] cnt,
                                        input logic [31:0] addr, input logic [14:0] bytes,
                                        input logic [31:0] page, input logic [47:0] lo,
                                        input logic [47:0] hi, input bit last);
    window_t w;
    w.start_frame    = frame;
    w.packet_count   = cnt;
    w.window_address = addr;
    w.window_bytes   = bytes;
    w.page_base      = page;
    w.lengths_low    = lo;
    w.lengths_high   = hi;
    w.last_window    = last;
    return w;
  endfunction

  // Present one packet, hold it until transferred, then predict its windows.
  // A typed row replaces the predicted final window with the hand-written one.
  task automatic push_packet(input in_item_t p, input bit typed, input window_t want);
    window_t w;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.packet_address    <= p.packet_address;
    in_ch.packet_length     <= p.packet_length;
    in_ch.first_of_transfer <= p.first_of_transfer;
    in_ch.last_of_transfer  <= p.last_of_transfer;
    in_ch.frame_now         <= p.frame_now;
    in_ch.tail_frame        <= p.tail_frame;
    in_ch.tail_valid        <= p.tail_valid;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    packets_sent++;
    pack_packet(p);
    while (fresh.size() > 0) begin
      w = fresh.pop_front();
      if (typed && fresh.size() == 0)
        w = want;
      windows_due.push_back(w);
    end
  endtask

  // Drop valid, let every owed window arrive, then hold the inputs idle before
  // returning.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (windows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_lookahead(input logic [LOOK_W-1:0] value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    pk_lookahead = value;
    settings_used++;
  endtask

  // Zero, maximum and small lengths are weighted up; the rest is uniform.
  function automatic len_t pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 20) return 12'hFFF;
    if (r < 55) return len_t'($urandom_range(1, 256));
    return len_t'($urandom_range(0, 4095));
  endfunction

  // One transfer of contiguous packets with random content; now and then
  // break the address chain or drop/duplicate a transfer flag.
  task automatic send_transfer(inout int sent);
    int                 n;
    int                 mode;
    logic [ADDR_W-1:0]  addr;
    in_item_t           p;
    n    = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 9);
    mode = $urandom_range(0, 3);
    case (mode)
      0: begin
        addr = $urandom();
      end
      1: begin
        // start near the end of a page to force early page splits
        addr = ($urandom() & 32'hFFFF_F000) | (32'hFFF - $urandom_range(0, 255));
      end
      2: begin
        // start near the top of the address space to exercise the wrap
        addr = 32'hFFFF_C000 + $urandom_range(0, 32'h3FFF);
      end
      default: begin
        addr = $urandom() & 32'hFFFF_F000;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      p.packet_length     = pick_length();
      p.packet_address    = addr;
      if (i > 0 && $urandom_range(0, 99) < 4)
        p.packet_address = $urandom();
      p.first_of_transfer = (i == 0);
      p.last_of_transfer  = (i == n - 1);
      if ($urandom_range(0, 99) < 2) p.first_of_transfer = ~p.first_of_transfer;
      if ($urandom_range(0, 99) < 2) p.last_of_transfer  = ~p.last_of_transfer;
      p.frame_now  = 16'($urandom());
      if ($urandom_range(0, 1))
        p.tail_frame = p.frame_now + 16'($urandom_range(0, 40)) - 16'd20;
      else
        p.tail_frame = 16'($urandom());
      p.tail_valid = 1'($urandom_range(0, 1));
      push_packet(p, 1'b0, NO_WINDOW);
      sent++;
      addr = p.packet_address + {20'd0, p.packet_length};
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random backpressure and the window checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_windows
    window_t got;
    window_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.start_frame, out_ch.packet_count, out_ch.window_address,
              out_ch.window_bytes, out_ch.page_base, out_ch.lengths_low,
              out_ch.lengths_high, out_ch.last_window};
      if (windows_due.size() == 0) begin
        flag_error("unexpected window at", got.window_address, '0);
      end else begin
        want = windows_due.pop_front();
        windows_checked++;
        if (got.start_frame !== want.start_frame)
          flag_error("start_frame", got.start_frame, want.start_frame);
        if (got.packet_count !== want.packet_count)
          flag_error("packet_count", got.packet_count, want.packet_count);
        if (got.window_address !== want.window_address)
          flag_error("window_address", got.window_address, want.window_address);
        if (got.window_bytes !== want.window_bytes)
          flag_error("window_bytes", got.window_bytes, want.window_bytes);
        if (got.page_base !== want.page_base)
          flag_error("page_base", got.page_base, want.page_base);
        if (got.lengths_low !== want.lengths_low)
          flag_error("lengths_low", got.lengths_low, want.lengths_low);
        if (got.lengths_high !== want.lengths_high)
          flag_error("lengths_high", got.lengths_high, want.lengths_high);
        if (got.last_window !== want.last_window)
          flag_error("last_window", got.last_window, want.last_window);
      end
    end
  end

  // Watchdog: a hung handshake or a lost window ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d windows still owed",
               cycle_count, windows_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    row_t               plan [PLAN_ROWS];
    in_item_t           p;
    int                 sent;
    logic [LOOK_W-1:0]  settings [4];

    // Known values on every input from time zero.
    rst_n                   = 1'b0;
    calm                    = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.packet_address    = '0;
    in_ch.packet_length     = '0;
    in_ch.first_of_transfer = 1'b0;
    in_ch.last_of_transfer  = 1'b0;
    in_ch.frame_now         = '0;
    in_ch.tail_frame        = '0;
    in_ch.tail_valid        = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.data             = '0;

    // Predictor matches the packer's reset state.
    pk_lookahead = LOOKAHEAD_RESET;
    pk_open      = 1'b0;
    pk_page      = '0;
    pk_addr      = '0;
    pk_bytes     = '0;
    pk_next_addr = '0;
    pk_count     = '0;
    pk_frame     = '0;
    foreach (pk_lens[s]) pk_lens[s] = '0;

    // Single-packet transfers with typed results (lookahead still at reset).
    // all-zero packet, no tail: frame 0 plus lookahead
    plan[0]  = '{mk_packet(32'h0000_0000, 12'h000, 1, 1, 16'h0000, 16'h0000, 0), 1,
                 mk_window(16'h0002, 4'd1, 32'h0000_0000, 15'h000, 32'h0000_0000,
                           48'h0, 48'h0, 1)};
    // all-ones packet; tail equal to now is not ahead, frame wraps
    plan[1]  = '{mk_packet(32'hFFFF_FFFF, 12'hFFF, 1, 1, 16'hFFFF, 16'hFFFF, 1), 1,
                 mk_window(16'h0001, 4'd1, 32'hFFFF_FFFF, 15'hFFF, 32'hFFFF_F000,
                           48'hFFF, 48'h0, 1)};
    // primed endpoint with tail ahead: take the tail frame
    plan[2]  = '{mk_packet(32'h1234_5678, 12'h800, 1, 1, 16'h1000, 16'h1005, 1), 1,
                 mk_window(16'h1005, 4'd1, 32'h1234_5678, 15'h800, 32'h1234_5000,
                           48'h800, 48'h0, 1)};
    // tail exactly half the frame space ahead reads as behind
    plan[3]  = '{mk_packet(32'h8000_0000, 12'h001, 1, 1, 16'h0000, 16'h8000, 1), 1,
                 mk_window(16'h0002, 4'd1, 32'h8000_0000, 15'h001, 32'h8000_0000,
                           48'h1, 48'h0, 1)};
    // largest positive lead still takes the tail
    plan[4]  = '{mk_packet(32'h0000_0ABC, 12'h000, 1, 1, 16'h0001, 16'h8000, 1), 1,
                 mk_window(16'h8000, 4'd1, 32'h0000_0ABC, 15'h000, 32'h0000_0000,
                           48'h0, 48'h0, 1)};
    // tail ahead but endpoint unprimed: ignore the tail
    plan[5]  = '{mk_packet(32'hFFFF_F000, 12'h001, 1, 1, 16'h0010, 16'h0020, 0), 1,
                 mk_window(16'h0012, 4'd1, 32'hFFFF_F000, 15'h001, 32'hFFFF_F000,
                           48'h1, 48'h0, 1)};
    // Nine contiguous packets: the ninth finds the window full and closes it,
    // then closes its own window as the last one.
    plan[6]  = '{mk_packet(32'h4000_0000, 12'h100, 1, 0, 16'h0300, 16'h0000, 0), 0, NO_WINDOW};
    plan[7]  = '{mk_packet(32'h4000_0100, 12'h100, 0, 0, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    plan[8]  = '{mk_packet(32'h4000_0200, 12'h100, 0, 0, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    plan[9]  = '{mk_packet(32'h4000_0300, 12'h100, 0, 0, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    plan[10] = '{mk_packet(32'h4000_0400, 12'h100, 0, 0, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    plan[11] = '{mk_packet(32'h4000_0500, 12'h100, 0, 0, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    plan[12] = '{mk_packet(32'h4000_0600, 12'h100, 0, 0, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    plan[13] = '{mk_packet(32'h4000_0700, 12'h100, 0, 0, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    plan[14] = '{mk_packet(32'h4000_0800, 12'h100, 0, 1, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    // Page rule: a zero-length slot, a packet ending in the next page, one
    // ending on its last byte, then one spilling into a third page.
    plan[15] = '{mk_packet(32'h2000_0F00, 12'h100, 1, 0, 16'h0100, 16'h0105, 1), 0, NO_WINDOW};
    plan[16] = '{mk_packet(32'h2000_1000, 12'h000, 0, 0, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    plan[17] = '{mk_packet(32'h2000_1000, 12'hFFF, 0, 0, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    plan[18] = '{mk_packet(32'h2000_1FFF, 12'h001, 0, 0, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    plan[19] = '{mk_packet(32'h2000_2000, 12'h001, 0, 0, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    // address gap closes the window; a new transfer start then drops the
    // stale one unemitted
    plan[20] = '{mk_packet(32'h3000_0000, 12'h010, 0, 0, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    plan[21] = '{mk_packet(32'h5000_0000, 12'h020, 1, 0, 16'h0200, 16'h0000, 0), 0, NO_WINDOW};
    // address wrap: the next page after the top one is page zero
    plan[22] = '{mk_packet(32'hFFFF_F800, 12'h800, 1, 0, 16'hFFFE, 16'h0003, 1), 0, NO_WINDOW};
    plan[23] = '{mk_packet(32'h0000_0000, 12'h010, 0, 1, 16'h0000, 16'h0000, 0), 0, NO_WINDOW};
    // packet with no transfer start opens a window at the running frame
    plan[24] = '{mk_packet(32'h6000_0000, 12'h040, 0, 1, 16'h1234, 16'h4321, 1), 0, NO_WINDOW};

    // Hold reset, then release it once for the whole run.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++)
      push_packet(plan[r].pkt, plan[r].typed, plan[r].want);

    // Random phases, one lookahead setting each; the third runs without
    // any idling on either channel.
    settings[0] = 8'd0;
    settings[1] = 8'd255;
    settings[2] = 8'($urandom_range(1, 254));
    settings[3] = 8'($urandom_range(0, 255));
    for (int ph = 0; ph < 4; ph++) begin
      write_lookahead(settings[ph]);
      calm = (ph == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) begin
          send_transfer(sent);
        end else begin
          // noise: any field value, flags mostly clear
          p = mk_packet($urandom(), len_t'($urandom_range(0, 4095)),
                        $urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0,
                        16'($urandom()), 16'($urandom()), 1'($urandom_range(0, 1)));
          push_packet(p, 1'b0, NO_WINDOW);
          sent++;
        end
      end
      calm = 1'b0;
    end

    settle();
    repeat (8) @(posedge clk);

    $display("covered %0d packets and %0d windows under %0d lookahead settings",
             packets_sent, windows_checked, settings_used);
    $display("%0d mismatches in %0d cycles", errors, cycle_count);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
